[src/lde_pkg.sv]
package lde_pkg;

    localparam int unsigned LINE_DEPTH_DEF = 16;

    localparam int unsigned KEY_W       = 8;
    localparam int unsigned COL_W       = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 16;
    localparam int unsigned M_TUSER_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_EDITING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ECHO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UTF8_MODE    = 2'd2;

    // Key codes, with the special-key flag as bit 8.
    localparam logic [8:0] KEY_BS_SPECIAL  = 9'h108;
    localparam logic [8:0] KEY_DEL_SPECIAL = 9'h17F;
    localparam logic [8:0] KEY_WERASE      = 9'h017;
    localparam logic [8:0] KEY_KILL        = 9'h015;
    localparam logic [8:0] KEY_INTR        = 9'h003;
    localparam logic [8:0] KEY_QUIT        = 9'h01C;
    localparam logic [8:0] KEY_SUSP        = 9'h01A;
    localparam logic [8:0] KEY_REDRAW      = 9'h012;
    localparam logic [8:0] KEY_LNEXT       = 9'h016;
    localparam logic [8:0] KEY_EOF         = 9'h004;
    localparam logic [8:0] KEY_ENTER       = 9'h10D;
    localparam logic [8:0] KEY_CR          = 9'h00D;

    // Byte ranges and fixed output values.
    localparam logic [7:0] PRINT_MIN    = 8'h20;
    localparam logic [7:0] PRINT_MAX    = 8'h7E;
    localparam logic [7:0] DEL_CHAR     = 8'h7F;
    localparam logic [7:0] HIGH_MIN     = 8'h80;
    localparam logic [7:0] LATIN_MIN    = 8'hA0;
    localparam logic [7:0] UTF8_LEAD    = 8'hC0;
    localparam logic [7:0] CARET_OFFSET = 8'h40;
    localparam logic [7:0] CHAR_QMARK   = 8'h3F;
    localparam logic [7:0] CHAR_R       = 8'h52;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;

    typedef enum logic [2:0] {
        ACT_CHILD  = 3'd0,
        ACT_RAW    = 3'd1,
        ACT_CARET  = 3'd2,
        ACT_HEX    = 3'd3,
        ACT_ERASE  = 3'd4,
        ACT_CRLF   = 3'd5,
        ACT_HEADER = 3'd6,
        ACT_DROP   = 3'd7
    } action_t;

    // What an accepted key asks for.
    typedef enum logic [3:0] {
        OP_PASS   = 4'd0,
        OP_CHAR   = 4'd1,
        OP_WORD   = 4'd2,
        OP_KILL   = 4'd3,
        OP_REDRAW = 4'd4,
        OP_QUOTE  = 4'd5,
        OP_EOF    = 4'd6,
        OP_ENTER  = 4'd7,
        OP_ORD    = 4'd8
    } op_t;

    // Which result the datapath builds when told to emit.
    typedef enum logic [3:0] {
        EM_CHILD_RD  = 4'd0,
        EM_CHILD_KEY = 4'd1,
        EM_CHILD_CR  = 4'd2,
        EM_ECHO_RD   = 4'd3,
        EM_ECHO_KEY  = 4'd4,
        EM_RAW_KEY   = 4'd5,
        EM_ERASE     = 4'd6,
        EM_CRLF      = 4'd7,
        EM_HEADER    = 4'd8,
        EM_DROP      = 4'd9
    } emit_t;

    typedef struct packed {
        logic  emit;
        emit_t kind;
        logic  load_key;
        logic  ptr_zero;
        logic  ptr_inc;
        logic  ptr_top;
        logic  drop;
        logic  save_prev;
        logic  clear_fill;
        logic  store;
        logic  set_quote;
        logic  clr_quote;
        logic  flush_hold;
    } lde_cmd_t;

    typedef struct packed {
        op_t  op;
        logic echo;
        logic fill_zero;
        logic full;
        logic ptr_last;
        logic rd_width_nz;
        logic stop_char;
        logic stop_word;
        logic emit_ok;
        logic out_free;
        logic hold_valid;
    } lde_status_t;

    function automatic op_t key_op(input logic [7:0] key, input logic special,
                                   input logic inter, input logic quote,
                                   input logic editing);
        logic [8:0] c;
        op_t        op;
        c = {special, key};
        if (!inter && c == KEY_CR) begin
            c = KEY_ENTER;
        end
        if (!editing) begin
            op = OP_PASS;
        end else if (quote) begin
            op = OP_ORD;
        end else begin
            unique case (c)
                KEY_BS_SPECIAL, KEY_DEL_SPECIAL:         op = OP_CHAR;
                KEY_WERASE:                              op = OP_WORD;
                KEY_KILL, KEY_INTR, KEY_QUIT, KEY_SUSP:  op = OP_KILL;
                KEY_REDRAW:                              op = OP_REDRAW;
                KEY_LNEXT:                               op = OP_QUOTE;
                KEY_EOF:                                 op = OP_EOF;
                KEY_ENTER:                               op = OP_ENTER;
                default:                                 op = OP_ORD;
            endcase
        end
        return op;
    endfunction

    // Screen columns taken by a buffered byte.
    function automatic logic [COL_W-1:0] width_of(input logic [7:0] c, input logic utf8);
        logic [COL_W-1:0] w;
        if ((c >= PRINT_MIN && c <= PRINT_MAX) || (c >= LATIN_MIN && !utf8)) begin
            w = 3'd1;
        end else if (c < HIGH_MIN) begin
            w = 3'd2;
        end else if (utf8 && c >= UTF8_LEAD) begin
            w = 3'd1;
        end else if (utf8) begin
            w = 3'd0;
        end else begin
            w = 3'd4;
        end
        return w;
    endfunction

    function automatic action_t echo_act(input logic [7:0] c, input logic utf8);
        action_t a;
        if ((c >= PRINT_MIN && c <= PRINT_MAX) || (!utf8 && c >= LATIN_MIN)
                || (utf8 && c >= HIGH_MIN)) begin
            a = ACT_RAW;
        end else if (c < HIGH_MIN) begin
            a = ACT_CARET;
        end else begin
            a = ACT_HEX;
        end
        return a;
    endfunction

    function automatic logic [7:0] echo_val(input logic [7:0] c, input logic utf8);
        logic [7:0] v;
        if (echo_act(c, utf8) == ACT_CARET) begin
            v = (c == DEL_CHAR) ? CHAR_QMARK : c + CARET_OFFSET;
        end else begin
            v = c;
        end
        return v;
    endfunction

    function automatic logic starts_char(input logic [7:0] c, input logic utf8);
        return !utf8 || c < HIGH_MIN || c >= UTF8_LEAD;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

[src/line_edit_discipline_core.sv]
// Channel   Direction  Handshake             Word contents
// s_        in         s_tvalid / s_tready   tdata: key byte; tuser: special, interactive
// m_        out        m_tvalid / m_tready   tdata: value, columns; tuser: action; tlast
// cfg_      in         cfg_wr_en only        index 0 editing, 1 echo, 2 utf8
//
// A line send, erase or redraw steps through the buffered bytes one at a time;
// a full line holds 16 bytes.
// Unless stalled, the line store is read one entry per cycle through its single read port.
// Reset clears fill level, quote flag and configuration; store contents are not cleared.
// Each result word is held one stage so the final one can carry tlast; a stalled
// m_tready freezes the sequencer, and no new key is taken until the final word of
// the current key has moved into the output register.
module line_edit_discipline_core #(
    parameter int unsigned LINE_DEPTH = lde_pkg::LINE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lde_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] key_byte
    input  logic [lde_pkg::S_TUSER_W-1:0]  s_tuser,  // [0] special_key, [1] interactive
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lde_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] value, [10:8] columns
    output logic [lde_pkg::M_TUSER_W-1:0]  m_tuser,  // [2:0] action
    output logic                           m_tlast
);
    import lde_pkg::*;

    lde_cmd_t    cmd;
    lde_status_t st;

    lde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lde_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

[src/lde_ram.sv]
module lde_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/lde_ctrl.sv]
module lde_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lde_pkg::lde_status_t st,
    output lde_pkg::lde_cmd_t    cmd
);
    import lde_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE       = 14'h0001,
        S_DECODE     = 14'h0002,
        S_SEND       = 14'h0004,
        S_ERASE      = 14'h0008,
        S_CR         = 14'h0010,
        S_CRLF       = 14'h0020,
        S_HDR        = 14'h0040,
        S_REDRAW     = 14'h0080,
        S_PASS_ECHO  = 14'h0100,
        S_PASS_CHILD = 14'h0200,
        S_STORE      = 14'h0400,
        S_ECHO_KEY   = 14'h0800,
        S_DROPPED    = 14'h1000,
        S_FINISH     = 14'h2000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   first_reg, first_next;

    logic want;
    logic go;
    logic stop;
    logic mode_stop;

    always_comb begin
        case (op_reg)
            OP_CHAR: mode_stop = st.stop_char;
            OP_WORD: mode_stop = st.stop_word;
            default: mode_stop = 1'b0;
        endcase
        stop = st.fill_zero || (!first_reg && mode_stop);
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        first_next = first_reg;
        s_tready   = 1'b0;
        want       = 1'b0;

        // A result can only be taken when the hold stage can make room.
        unique case (state_reg)
            S_SEND:       want = 1'b1;
            S_CR:         want = 1'b1;
            S_CRLF:       want = 1'b1;
            S_HDR:        want = 1'b1;
            S_REDRAW:     want = 1'b1;
            S_PASS_CHILD: want = 1'b1;
            S_ECHO_KEY:   want = 1'b1;
            S_DROPPED:    want = 1'b1;
            S_PASS_ECHO:  want = st.echo;
            S_ERASE:      want = !stop && (op_reg == OP_PASS || st.echo) && st.rd_width_nz;
            default:      want = 1'b0;
        endcase
        go = !want || st.emit_ok;
        cmd.emit = want && go;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_key = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                op_next = st.op;
                unique case (st.op)
                    OP_PASS: begin
                        if (st.fill_zero) begin
                            state_next = S_PASS_ECHO;
                        end else begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = S_SEND;
                        end
                    end
                    OP_CHAR, OP_WORD, OP_KILL: begin
                        cmd.ptr_top = 1'b1;
                        first_next  = 1'b1;
                        state_next  = S_ERASE;
                    end
                    OP_REDRAW: state_next = st.echo ? S_HDR : S_FINISH;
                    OP_QUOTE: begin
                        cmd.set_quote = 1'b1;
                        state_next    = S_FINISH;
                    end
                    OP_EOF: begin
                        if (st.fill_zero) begin
                            state_next = S_FINISH;
                        end else begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = S_SEND;
                        end
                    end
                    OP_ENTER: begin
                        if (st.fill_zero) begin
                            state_next = S_CR;
                        end else begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = S_SEND;
                        end
                    end
                    default: state_next = st.full ? S_DROPPED : S_STORE;
                endcase
            end
            S_SEND: begin
                cmd.kind = EM_CHILD_RD;
                if (go) begin
                    if (st.ptr_last) begin
                        case (op_reg)
                            OP_PASS: begin
                                // The flushed line is then wiped from the screen.
                                cmd.ptr_top = 1'b1;
                                first_next  = 1'b1;
                                state_next  = S_ERASE;
                            end
                            OP_ENTER: begin
                                cmd.clear_fill = 1'b1;
                                state_next     = st.echo ? S_CRLF : S_FINISH;
                            end
                            default: begin
                                cmd.clear_fill = 1'b1;
                                state_next     = S_FINISH;
                            end
                        endcase
                    end else begin
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end
            S_ERASE: begin
                cmd.kind = EM_ERASE;
                if (stop) begin
                    state_next = (op_reg == OP_PASS) ? S_PASS_ECHO : S_FINISH;
                end else if (go) begin
                    cmd.drop      = 1'b1;
                    cmd.save_prev = 1'b1;
                    first_next    = 1'b0;
                end
            end
            S_CR: begin
                cmd.kind = EM_CHILD_CR;
                if (go) begin
                    state_next = st.echo ? S_CRLF : S_FINISH;
                end
            end
            S_CRLF: begin
                cmd.kind = EM_CRLF;
                if (go) begin
                    state_next = S_FINISH;
                end
            end
            S_HDR: begin
                cmd.kind = EM_HEADER;
                if (go) begin
                    cmd.ptr_zero = 1'b1;
                    state_next   = st.fill_zero ? S_FINISH : S_REDRAW;
                end
            end
            S_REDRAW: begin
                cmd.kind = EM_ECHO_RD;
                if (go) begin
                    if (st.ptr_last) begin
                        state_next = S_FINISH;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end
            S_PASS_ECHO: begin
                cmd.kind = EM_RAW_KEY;
                if (go) begin
                    state_next = S_PASS_CHILD;
                end
            end
            S_PASS_CHILD: begin
                cmd.kind = EM_CHILD_KEY;
                if (go) begin
                    state_next = S_FINISH;
                end
            end
            S_STORE: begin
                cmd.store     = 1'b1;
                cmd.clr_quote = 1'b1;
                state_next    = st.echo ? S_ECHO_KEY : S_FINISH;
            end
            S_ECHO_KEY: begin
                cmd.kind = EM_ECHO_KEY;
                if (go) begin
                    state_next = S_FINISH;
                end
            end
            S_DROPPED: begin
                cmd.kind = EM_DROP;
                if (go) begin
                    cmd.clr_quote = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                // The held result is the final one of this key; mark it last.
                if (!st.hold_valid) begin
                    state_next = S_IDLE;
                end else if (st.out_free) begin
                    cmd.flush_hold = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PASS;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            first_reg <= first_next;
        end
    end

endmodule

[src/lde_datapath.sv]
module lde_datapath #(
    parameter int unsigned LINE_DEPTH = lde_pkg::LINE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_wr_data,
    input  logic [lde_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [lde_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lde_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [lde_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast,
    input  lde_pkg::lde_cmd_t                  cmd,
    output lde_pkg::lde_status_t               st
);
    import lde_pkg::*;

    localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
    localparam int unsigned FILL_W = $clog2(LINE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_DEPTH);

    logic line_editing_reg, local_echo_reg, utf8_mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic special_reg, inter_reg;
    logic quote_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [KEY_W-1:0]  prev_reg;
    logic [KEY_W-1:0]  rd_data;
    logic [FILL_W-1:0] fill_m1;

    logic             hold_valid_reg;
    action_t          hold_act_reg;
    logic [KEY_W-1:0] hold_val_reg;
    logic [COL_W-1:0] hold_cols_reg;
    logic             out_valid_reg;
    action_t          out_act_reg;
    logic [KEY_W-1:0] out_val_reg;
    logic [COL_W-1:0] out_cols_reg;
    logic             out_last_reg;
    logic             out_free;

    action_t          new_act;
    logic [KEY_W-1:0] new_val;
    logic [COL_W-1:0] new_cols;

    assign fill_m1  = fill_reg - FILL_W'(1);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        st.op          = key_op(key_reg, special_reg, inter_reg, quote_reg, line_editing_reg);
        st.echo        = local_echo_reg;
        st.fill_zero   = fill_reg == '0;
        st.full        = fill_reg == FILL_MAX;
        st.ptr_last    = FILL_W'(ptr_reg) == fill_m1;
        st.rd_width_nz = width_of(rd_data, utf8_mode_reg) != '0;
        st.stop_char   = starts_char(prev_reg, utf8_mode_reg);
        st.stop_word   = is_space(rd_data) && !is_space(prev_reg);
        st.emit_ok     = !hold_valid_reg || out_free;
        st.out_free    = out_free;
        st.hold_valid  = hold_valid_reg;
    end

    // Read address follows the pointer's next value, so rd_data always
    // shows the entry at ptr_reg.
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_zero) begin
            ptr_next = '0;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end else if (cmd.ptr_top) begin
            ptr_next = fill_m1[ADDR_W-1:0];
        end else if (cmd.drop) begin
            ptr_next = (fill_reg == FILL_W'(1)) ? '0 : fill_m1[ADDR_W-1:0] - ADDR_W'(1);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear_fill) begin
            fill_next = '0;
        end else if (cmd.drop) begin
            fill_next = fill_m1;
        end else if (cmd.store) begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    lde_ram #(
        .WIDTH (KEY_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    always_comb begin
        new_act  = ACT_CHILD;
        new_val  = '0;
        new_cols = '0;
        unique case (cmd.kind)
            EM_CHILD_RD:  new_val = rd_data;
            EM_CHILD_KEY: new_val = key_reg;
            EM_CHILD_CR:  new_val = CHAR_CR;
            EM_ECHO_RD: begin
                new_act = echo_act(rd_data, utf8_mode_reg);
                new_val = echo_val(rd_data, utf8_mode_reg);
            end
            EM_ECHO_KEY: begin
                new_act = echo_act(key_reg, utf8_mode_reg);
                new_val = echo_val(key_reg, utf8_mode_reg);
            end
            EM_RAW_KEY: begin
                new_act = ACT_RAW;
                new_val = key_reg;
            end
            EM_ERASE: begin
                new_act  = ACT_ERASE;
                new_cols = width_of(rd_data, utf8_mode_reg);
            end
            EM_CRLF:      new_act = ACT_CRLF;
            EM_HEADER: begin
                new_act = ACT_HEADER;
                new_val = CHAR_R;
            end
            EM_DROP: begin
                new_act = ACT_DROP;
                new_val = key_reg;
            end
            default: new_act = ACT_CHILD;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_editing_reg <= 1'b0;
            local_echo_reg   <= 1'b0;
            utf8_mode_reg    <= 1'b0;
            fill_reg         <= '0;
            quote_reg        <= 1'b0;
            ptr_reg          <= '0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LINE_EDITING: line_editing_reg <= cfg_wr_data;
                    REG_LOCAL_ECHO:   local_echo_reg   <= cfg_wr_data;
                    REG_UTF8_MODE:    utf8_mode_reg    <= cfg_wr_data;
                    default: ;
                endcase
            end
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (cmd.set_quote) begin
                quote_reg <= 1'b1;
            end else if (cmd.clr_quote) begin
                quote_reg <= 1'b0;
            end

            if (cmd.emit) begin
                hold_valid_reg <= 1'b1;
            end else if (cmd.flush_hold) begin
                hold_valid_reg <= 1'b0;
            end

            if ((cmd.emit && hold_valid_reg) || cmd.flush_hold) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg     <= s_tdata[KEY_W-1:0];
            special_reg <= s_tuser[0];
            inter_reg   <= s_tuser[1];
        end
        if (cmd.save_prev) begin
            prev_reg <= rd_data;
        end
        if (cmd.emit) begin
            hold_act_reg  <= new_act;
            hold_val_reg  <= new_val;
            hold_cols_reg <= new_cols;
        end
        if ((cmd.emit && hold_valid_reg) || cmd.flush_hold) begin
            out_act_reg  <= hold_act_reg;
            out_val_reg  <= hold_val_reg;
            out_cols_reg <= hold_cols_reg;
            out_last_reg <= cmd.flush_hold;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_W - COL_W){1'b0}}, out_cols_reg, out_val_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("line fill level beyond depth");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && hold_valid_reg |-> out_free)
        else $error("result emitted while output stage blocked");

    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> fill_reg != FILL_MAX)
        else $error("store into full line");

    a_drop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drop |-> fill_reg != '0)
        else $error("erase from empty line");

    a_flush_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush_hold |-> hold_valid_reg && out_free && !cmd.emit)
        else $error("final word pushed without a held result or room");

endmodule
